// ===== hdl/bspt_pkg.sv =====
package bspt_pkg;

   // Pool size and the widths that follow from it.
   localparam int POOL_SLOTS = 32;
   localparam int ADDR_W     = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
   localparam int CNT_W      = $clog2(POOL_SLOTS + 1);
   // Wide enough to hold any slot index and the pool size itself.
   localparam int SEL_WIDE_W = 11;

   // Field widths.
   localparam int MODE_W   = 2;
   localparam int HANDLE_W = 16;
   localparam int COLOR_W  = 8;
   localparam int WIDTH_W  = 16;
   localparam int ID_W     = 32;
   localparam int SEL_W    = 5;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 5;

   localparam logic [ID_W-1:0] ID_START = ID_W'(1);

   typedef enum logic [MODE_W-1:0] {
      MODE_ADD,
      MODE_FIND_OWNER,
      MODE_FIND_ID,
      MODE_REMOVE
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK,
      STATUS_NOT_FOUND,
      STATUS_FULL
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_BUSY
   } state_type;

   typedef struct packed {
      mode_type              mode;
      logic [HANDLE_W-1:0]   owner_handle;
      logic [HANDLE_W-1:0]   target_handle;
      logic [COLOR_W-1:0]    beam_color;
      logic [WIDTH_W-1:0]    beam_width;
      logic [ID_W-1:0]       search_id;
      logic [SEL_W-1:0]      slot_sel;
   } req_type;

   // One slot of the pool as it is kept in the slot memory.
   typedef struct packed {
      logic [ID_W-1:0]       id;
      logic [WIDTH_W-1:0]    width;
      logic [COLOR_W-1:0]    color;
      logic [HANDLE_W-1:0]   target;
      logic [HANDLE_W-1:0]   owner;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic step;
      logic commit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic immediate;
      logic hit;
      logic scan_end;
      logic out_free;
   } sts_type;

endpackage

// ===== hdl/bspt_req_if.sv =====
interface bspt_req_if
   import bspt_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [HANDLE_W-1:0] owner_handle;
   logic [HANDLE_W-1:0] target_handle;
   logic [COLOR_W-1:0]  beam_color;
   logic [WIDTH_W-1:0]  beam_width;
   logic [ID_W-1:0]     search_id;
   logic [SEL_W-1:0]    slot_sel;

   modport source (
      output valid, mode, owner_handle, target_handle, beam_color, beam_width,
             search_id, slot_sel,
      input  ready
   );

   modport sink (
      input  valid, mode, owner_handle, target_handle, beam_color, beam_width,
             search_id, slot_sel,
      output ready
   );
endinterface

// ===== hdl/bspt_rsp_if.sv =====
interface bspt_rsp_if
   import bspt_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [INDEX_W-1:0]  slot_index;
   logic [ID_W-1:0]     found_id;
   logic [HANDLE_W-1:0] found_owner;
   logic [HANDLE_W-1:0] found_target;
   logic [COLOR_W-1:0]  found_color;
   logic [WIDTH_W-1:0]  found_width;

   modport source (
      output valid, status, slot_index, found_id, found_owner, found_target,
             found_color, found_width,
      input  ready
   );

   modport sink (
      input  valid, status, slot_index, found_id, found_owner, found_target,
             found_color, found_width,
      output ready
   );
endinterface

// ===== hdl/bspt_ram.sv =====
module bspt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                   clock,
   input  logic                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]       wdata,
   input  logic                   re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]       rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ===== hdl/bspt_ctrl.sv =====
module bspt_ctrl
   import bspt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);
   state_type state_ff;
   state_type state_in;
   logic      done;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      done      = sts.immediate || sts.hit || sts.scan_end;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_BUSY;
            end
         end
         ST_BUSY: begin
            // Keep scanning until an answer is known; then wait for room
            // in the result register before committing.
            if (!done) begin
               cmd.step = 1'b1;
            end else if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
      endcase
   end

`ifndef SYNTH
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request taken while one is in progress");

   a_commit_has_room: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> sts.out_free)
      else $error("result committed over a pending result");
`endif
endmodule

// ===== hdl/bspt_datapath.sv =====
module bspt_datapath
   import bspt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  cmd_type    cmd,
   output sts_type    sts,
   bspt_rsp_if.source rsp_if
);
   req_type                 req_ff, req_in;
   logic [POOL_SLOTS-1:0]   valid_ff, valid_in;
   logic [ID_W-1:0]         next_id_ff, next_id_in;
   logic [CNT_W-1:0]        rd_addr_ff, rd_addr_in;
   logic [ADDR_W-1:0]       chk_idx_ff, chk_idx_in;
   logic                    chk_vld_ff, chk_vld_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              status_ff, status_in;
   logic [INDEX_W-1:0]      index_ff, index_in;
   entry_type               found_ff, found_in;

   entry_type               rd_entry;
   entry_type               wr_entry;
   mode_type                mode;
   logic [SEL_WIDE_W-1:0]   sel_wide;
   logic [SEL_WIDE_W-1:0]   chk_wide;
   logic [ADDR_W-1:0]       sel_addr;
   logic                    sel_in_range;
   logic                    chk_free;
   logic                    chk_match;
   logic                    issue;
   logic                    ram_we;

   assign mode         = req_ff.mode;
   assign sel_wide     = SEL_WIDE_W'(req_ff.slot_sel);
   assign sel_in_range = sel_wide < SEL_WIDE_W'(POOL_SLOTS);
   assign sel_addr     = sel_wide[ADDR_W-1:0];
   assign chk_wide     = SEL_WIDE_W'(chk_idx_ff);
   assign chk_free     = !valid_ff[chk_idx_ff];

   assign wr_entry.id     = next_id_ff;
   assign wr_entry.width  = req_ff.beam_width;
   assign wr_entry.color  = req_ff.beam_color;
   assign wr_entry.target = req_ff.target_handle;
   assign wr_entry.owner  = req_ff.owner_handle;

   // Match test on the entry whose read data is on the memory output.
   always_comb begin
      unique case (mode)
         MODE_ADD:        chk_match = chk_free;
         MODE_FIND_OWNER: chk_match = !chk_free && (rd_entry.owner == req_ff.owner_handle);
         MODE_FIND_ID:    chk_match = !chk_free && (rd_entry.id == req_ff.search_id);
         MODE_REMOVE:     chk_match = 1'b0;
      endcase
   end

   always_comb begin
      sts.immediate = (mode == MODE_REMOVE) ||
                      ((mode == MODE_ADD) && (req_ff.owner_handle == '0));
      sts.hit       = chk_vld_ff && chk_match;
      sts.scan_end  = chk_vld_ff && !chk_match &&
                      (chk_wide == SEL_WIDE_W'(POOL_SLOTS - 1));
      sts.out_free  = !rsp_valid_ff || rsp_if.ready;
   end

   assign issue  = cmd.step && (rd_addr_ff < CNT_W'(POOL_SLOTS));
   assign ram_we = cmd.commit && !sts.immediate && sts.hit && (mode == MODE_ADD);

   bspt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (POOL_SLOTS)
   ) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (chk_idx_ff),
      .wdata (wr_entry),
      .re    (issue),
      .raddr (rd_addr_ff[ADDR_W-1:0]),
      .rdata (rd_entry)
   );

   always_comb begin
      req_in       = req_ff;
      valid_in     = valid_ff;
      next_id_in   = next_id_ff;
      rd_addr_in   = rd_addr_ff;
      chk_idx_in   = chk_idx_ff;
      chk_vld_in   = chk_vld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      status_in    = status_ff;
      index_in     = index_ff;
      found_in     = found_ff;

      if (cmd.accept) begin
         req_in     = req_data;
         rd_addr_in = '0;
         chk_vld_in = 1'b0;
      end

      if (cmd.step) begin
         rd_addr_in = rd_addr_ff + CNT_W'(issue);
         chk_idx_in = rd_addr_ff[ADDR_W-1:0];
         chk_vld_in = issue;
      end

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         status_in    = STATUS_OK;
         index_in     = '0;
         found_in     = '0;
         if (sts.immediate) begin
            if (mode == MODE_REMOVE) begin
               if (sel_in_range) begin
                  valid_in[sel_addr] = 1'b0;
                  index_in           = req_ff.slot_sel;
               end else begin
                  status_in = STATUS_NOT_FOUND;
               end
            end else begin
               status_in = STATUS_FULL;
            end
         end else if (sts.hit) begin
            index_in = chk_wide[INDEX_W-1:0];
            if (mode == MODE_ADD) begin
               valid_in[chk_idx_ff] = 1'b1;
               next_id_in           = next_id_ff + ID_W'(1);
               found_in             = wr_entry;
            end else begin
               found_in = rd_entry;
            end
         end else if (mode == MODE_ADD) begin
            status_in = STATUS_FULL;
         end else begin
            status_in = STATUS_NOT_FOUND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         next_id_ff   <= ID_START;
         rd_addr_ff   <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         next_id_ff   <= next_id_in;
         rd_addr_ff   <= rd_addr_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      chk_idx_ff <= chk_idx_in;
      status_ff  <= status_in;
      index_ff   <= index_in;
      found_ff   <= found_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = status_ff;
   assign rsp_if.slot_index   = index_ff;
   assign rsp_if.found_id     = found_ff.id;
   assign rsp_if.found_owner  = found_ff.owner;
   assign rsp_if.found_target = found_ff.target;
   assign rsp_if.found_color  = found_ff.color;
   assign rsp_if.found_width  = found_ff.width;

`ifndef SYNTH
   a_write_free_slot: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> !valid_ff[chk_idx_ff])
      else $error("add wrote over an occupied slot");

   a_id_advances_on_add: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (next_id_ff != $past(next_id_ff))) |-> $past(ram_we))
      else $error("id counter moved without a successful add");
`endif
endmodule

// ===== hdl/beam_slot_pool_table_unit.sv =====
// Beam slot pool table: a fixed pool of POOL_SLOTS beam slots (32 by default).
// Each request transfer carries one operation: add places owner, target,
// color and width in the lowest free slot and tags it with a running 32-bit
// id that starts at 1; find by owner and find by id return the lowest
// occupied slot that matches, with all of its fields; remove frees the slot
// named by slot_sel. Every request produces exactly one response transfer.
// An add with a zero owner handle, or into a full pool, reports status 2 and
// changes nothing. Remove and an add with a zero owner answer without a scan;
// the other operations scan from slot 0 upward and stop at the first match,
// or after the last slot, so an add into a full pool reads every slot. No new
// request is taken until the current one is committed. The scan reads one slot
// entry per cycle from the single read port of the slot memory. Occupancy is
// held in one flip-flop per slot that reset clears, so no clearing pass is
// needed and the block takes a request in the first cycle after reset. The
// response sits in an output register; a new request is taken while an
// older response still waits, and the scan holds its answer until the
// response register is free.
module beam_slot_pool_table_unit
   import bspt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   bspt_req_if.sink   req_if,
   bspt_rsp_if.source rsp_if
);
   req_type req_data;
   cmd_type cmd;
   sts_type sts;
   logic    req_ready;

   // Gather the request fields into one word for the datapath.
   assign req_data.mode          = mode_type'(req_if.mode);
   assign req_data.owner_handle  = req_if.owner_handle;
   assign req_data.target_handle = req_if.target_handle;
   assign req_data.beam_color    = req_if.beam_color;
   assign req_data.beam_width    = req_if.beam_width;
   assign req_data.search_id     = req_if.search_id;
   assign req_data.slot_sel      = req_if.slot_sel;

   assign req_if.ready = req_ready;

   // The controller sequences accept, scan and commit; it only sees the
   // request handshake and the status summary from the datapath.
   bspt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the slot memory, occupancy bits, id counter, scan
   // counters and the response register.
   bspt_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_if   (rsp_if)
   );
endmodule

// ===== dv/beam_pool_checker.sv =====
`timescale 1ns / 1ps

module beam_pool_checker
   import bspt_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   bspt_req_if   req_mon,
   bspt_rsp_if   rsp_mon,
   output int    fail_count,
   output int    pending
);

   typedef struct packed {
      status_type            status;
      logic [INDEX_W-1:0]    slot_index;
      logic [ID_W-1:0]       id;
      logic [HANDLE_W-1:0]   owner;
      logic [HANDLE_W-1:0]   target;
      logic [COLOR_W-1:0]    color;
      logic [WIDTH_W-1:0]    width;
   } beam_answer_type;

   // Shadow copy of the slot pool.
   logic [HANDLE_W-1:0] pool_owner  [POOL_SLOTS];
   logic [HANDLE_W-1:0] pool_target [POOL_SLOTS];
   logic [COLOR_W-1:0]  pool_color  [POOL_SLOTS];
   logic [WIDTH_W-1:0]  pool_width  [POOL_SLOTS];
   logic [ID_W-1:0]     pool_id     [POOL_SLOTS];
   logic [ID_W-1:0]     id_counter;

   beam_answer_type expected_answers[$];

   function automatic beam_answer_type slot_view(int k);
      beam_answer_type a;
      a.status     = STATUS_OK;
      a.slot_index = INDEX_W'(k);
      a.id         = pool_id[k];
      a.owner      = pool_owner[k];
      a.target     = pool_target[k];
      a.color      = pool_color[k];
      a.width      = pool_width[k];
      return a;
   endfunction

   // Applies one request to the shadow pool and returns the answer it must give.
   function automatic beam_answer_type beam_pool_apply(
      input logic [MODE_W-1:0]   mode,
      input logic [HANDLE_W-1:0] owner,
      input logic [HANDLE_W-1:0] target,
      input logic [COLOR_W-1:0]  color,
      input logic [WIDTH_W-1:0]  width,
      input logic [ID_W-1:0]     sid,
      input logic [SEL_W-1:0]    sel
   );
      beam_answer_type a;
      int hit;
      a   = '0;
      hit = -1;
      case (mode_type'(mode))
         MODE_ADD: begin
            for (int k = 0; k < POOL_SLOTS; k++)
               if (hit < 0 && pool_owner[k] == '0) hit = k;
            if (owner == '0 || hit < 0) begin
               a.status = STATUS_FULL;
            end else begin
               pool_owner[hit]  = owner;
               pool_target[hit] = target;
               pool_color[hit]  = color;
               pool_width[hit]  = width;
               pool_id[hit]     = id_counter;
               id_counter       = id_counter + 1'b1;
               a = slot_view(hit);
            end
         end
         MODE_FIND_OWNER: begin
            // A zero handle never names an owner, even though free slots hold zero.
            if (owner != '0)
               for (int k = 0; k < POOL_SLOTS; k++)
                  if (hit < 0 && pool_owner[k] == owner) hit = k;
            if (hit < 0) a.status = STATUS_NOT_FOUND;
            else a = slot_view(hit);
         end
         MODE_FIND_ID: begin
            for (int k = 0; k < POOL_SLOTS; k++)
               if (hit < 0 && pool_owner[k] != '0 && pool_id[k] == sid) hit = k;
            if (hit < 0) a.status = STATUS_NOT_FOUND;
            else a = slot_view(hit);
         end
         default: begin
            if (int'(sel) >= POOL_SLOTS) begin
               a.status = STATUS_NOT_FOUND;
            end else begin
               pool_owner[sel] = '0;
               a.slot_index    = INDEX_W'(sel);
            end
         end
      endcase
      return a;
   endfunction

   function automatic bit field_ok(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      beam_answer_type want;
      bit ok;
      if (reset) begin
         for (int k = 0; k < POOL_SLOTS; k++) begin
            pool_owner[k]  = '0;
            pool_target[k] = '0;
            pool_color[k]  = '0;
            pool_width[k]  = '0;
            pool_id[k]     = '0;
         end
         id_counter = ID_START;
         expected_answers.delete();
         fail_count <= 0;
         pending    <= 0;
      end else begin
         // The new request is queued behind the older ones, so a response
         // in the same cycle still meets its own expectation at the front.
         if (req_mon.valid && req_mon.ready)
            expected_answers.push_back(beam_pool_apply(req_mon.mode, req_mon.owner_handle,
               req_mon.target_handle, req_mon.beam_color, req_mon.beam_width,
               req_mon.search_id, req_mon.slot_sel));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_answers.size() == 0) begin
               $display("%0t: response with no request waiting, expected none actual %h",
                        $time, rsp_mon.status);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_answers.pop_front();
               ok   = 1'b1;
               if (!field_ok("status", 32'(want.status), 32'(rsp_mon.status))) ok = 1'b0;
               if (!field_ok("slot_index", 32'(want.slot_index), 32'(rsp_mon.slot_index)))
                  ok = 1'b0;
               if (!field_ok("found_id", want.id, rsp_mon.found_id)) ok = 1'b0;
               if (!field_ok("found_owner", 32'(want.owner), 32'(rsp_mon.found_owner)))
                  ok = 1'b0;
               if (!field_ok("found_target", 32'(want.target), 32'(rsp_mon.found_target)))
                  ok = 1'b0;
               if (!field_ok("found_color", 32'(want.color), 32'(rsp_mon.found_color)))
                  ok = 1'b0;
               if (!field_ok("found_width", 32'(want.width), 32'(rsp_mon.found_width)))
                  ok = 1'b0;
               if (!ok) fail_count <= fail_count + 1;
            end
         end
         pending <= expected_answers.size();
      end
   end

endmodule

// ===== dv/tb_beam_slot_pool_table_unit.sv =====
`timescale 1ns / 1ps

module tb_beam_slot_pool_table_unit
   import bspt_pkg::*;
();

   // The drain wait at the end covers one full scan of the pool with
   // margin.
   localparam int DRAIN_CYCLES   = 48;
   // Length of the one long receiver hold-off.
   localparam int HOLD_CYCLES    = 220;
   // Cycles without any transfer before the run is declared hung. The slowest
   // correct gap is the hold-off plus a scan plus a long random stall.
   localparam int WATCHDOG_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int  fail_count;
   int  pending;
   int  ids_issued;

   // Flags set by the stimulus process and read by the receiver.
   bit  steady;       // both sides offer and accept every cycle
   bit  hold_req;     // ask the receiver for its long hold-off
   bit  hold_served;

   always #4 clock = ~clock;

   bspt_req_if req_ch();
   bspt_rsp_if rsp_ch();

   beam_slot_pool_table_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   beam_pool_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Idle the request side for a random run of cycles, about 29 in a hundred.
   // Valid is lowered here after a transfer, never in the same step in which
   // the next request raises it.
   task automatic sender_gap();
      if (!steady && $urandom_range(0, 99) < 29) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 29);
      end
   endtask

   // Offer one request and hold it until the block takes the transfer. Must be
   // called right after a rising edge.
   task automatic offer(
      input mode_type            mode,
      input logic [HANDLE_W-1:0] owner,
      input logic [HANDLE_W-1:0] target,
      input logic [COLOR_W-1:0]  color,
      input logic [WIDTH_W-1:0]  width,
      input logic [ID_W-1:0]     sid,
      input logic [SEL_W-1:0]    sel
   );
      req_ch.valid         <= 1'b1;
      req_ch.mode          <= mode;
      req_ch.owner_handle  <= owner;
      req_ch.target_handle <= target;
      req_ch.beam_color    <= color;
      req_ch.beam_width    <= width;
      req_ch.search_id     <= sid;
      req_ch.slot_sel      <= sel;
      do @(posedge clock); while (!req_ch.ready);
      sender_gap();
   endtask

   // One random request. Owners come mostly from a small set so that finds hit
   // and duplicates occur; ids are drawn near the range already handed out.
   // Zero owners, wide random owners and random ids are the noise.
   task automatic offer_random(input int add_pct, input int remove_pct);
      int                  pick;
      mode_type            mode;
      logic [HANDLE_W-1:0] owner;
      logic [ID_W-1:0]     sid;
      logic [SEL_W-1:0]    sel;
      pick = $urandom_range(0, 99);
      if (pick < add_pct) mode = MODE_ADD;
      else if (pick < add_pct + remove_pct) mode = MODE_REMOVE;
      else if ($urandom_range(0, 1) == 1) mode = MODE_FIND_OWNER;
      else mode = MODE_FIND_ID;
      pick = $urandom_range(0, 99);
      if (pick < 8) owner = '0;
      else if (pick < 30) owner = HANDLE_W'($urandom);
      else owner = HANDLE_W'($urandom_range(1, 24));
      if ($urandom_range(0, 99) < 70) sid = ID_W'($urandom_range(0, ids_issued + 1));
      else sid = $urandom;
      // Low slots are the ones that fill first, so removes lean toward them.
      if ($urandom_range(0, 1) == 1) sel = SEL_W'($urandom_range(0, 7));
      else sel = SEL_W'($urandom);
      if (mode == MODE_ADD && owner != '0) ids_issued++;
      offer(mode, owner, HANDLE_W'($urandom), COLOR_W'($urandom), WIDTH_W'($urandom),
            sid, sel);
   endtask

   // Stop offering and wait until every expected response has arrived. The
   // first edge is always waited so that the last transfer is counted.
   task automatic wait_all_answered();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Response side: random back-pressure, a stretch of always-ready while the
   // steady flag is up, and one long hold-off counted here.
   initial begin
      rsp_ch.ready = 1'b0;
      hold_served  = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req && !hold_served) begin
            hold_served = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 29);
         end
      end
   end

   // Watchdog: ends the run if no transfer happens on either channel for too
   // long.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
         else quiet++;
      end
      $display("beam_slot_pool_table_unit: mismatch");
      $finish;
   end

   initial begin
      req_ch.valid         = 1'b0;
      req_ch.mode          = MODE_ADD;
      req_ch.owner_handle  = '0;
      req_ch.target_handle = '0;
      req_ch.beam_color    = '0;
      req_ch.beam_width    = '0;
      req_ch.search_id     = '0;
      req_ch.slot_sel      = '0;
      steady      = 1'b0;
      hold_req    = 1'b0;
      ids_issued  = 2;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part. On an empty pool nothing is found, a zero owner is
      // never matched, and removing a free slot is still accepted.
      offer(MODE_FIND_OWNER, '0, '0, '0, '0, '0, '0);
      offer(MODE_FIND_ID, '0, '0, '0, '0, '0, '0);
      offer(MODE_FIND_ID, '0, '0, '0, '0, 32'd1, '0);
      offer(MODE_REMOVE, '0, '0, '0, '0, '0, 5'd31);
      // An add with a zero owner is rejected and does not consume an id.
      offer(MODE_ADD, '0, 16'hFFFF, 8'hFF, 16'hFFFF, '0, '0);
      // All-ones and minimal fields, then a duplicate owner.
      offer(MODE_ADD, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, '0, '0);
      offer(MODE_ADD, 16'h0001, '0, '0, '0, '0, '0);
      offer(MODE_ADD, 16'h0001, 16'h1234, 8'h5A, 16'hA5A5, '0, '0);
      offer(MODE_FIND_OWNER, 16'hFFFF, '0, '0, '0, '0, '0);
      // With two slots owned by the same handle, the lower one answers.
      offer(MODE_FIND_OWNER, 16'h0001, '0, '0, '0, '0, '0);
      offer(MODE_FIND_OWNER, '0, '0, '0, '0, '0, '0);
      offer(MODE_FIND_ID, '0, '0, '0, '0, 32'd3, '0);
      offer(MODE_FIND_ID, '0, '0, '0, '0, 32'hFFFF_FFFF, '0);
      offer(MODE_REMOVE, '0, '0, '0, '0, '0, 5'd1);
      offer(MODE_FIND_OWNER, 16'h0001, '0, '0, '0, '0, '0);
      // A freed slot keeps its old id, but it must no longer be found by it.
      offer(MODE_FIND_ID, '0, '0, '0, '0, 32'd2, '0);
      offer(MODE_REMOVE, '0, '0, '0, '0, '0, 5'd1);
      // The freed slot is the lowest free one and is reused.
      offer(MODE_ADD, 16'h8000, 16'h0001, 8'h80, 16'h0080, '0, '0);
      offer(MODE_FIND_ID, '0, '0, '0, '0, 32'd4, '0);
      offer(MODE_REMOVE, '0, '0, '0, '0, '0, 5'd0);
      offer(MODE_REMOVE, '0, '0, '0, '0, '0, 5'd2);
      offer(MODE_REMOVE, '0, '0, '0, '0, '0, 5'd1);
      offer(MODE_FIND_OWNER, 16'h8000, '0, '0, '0, '0, '0);
      ids_issued = 4;

      // Fill phase: mostly adds, so the pool runs full and adds are refused.
      for (int i = 0; i < 120; i++) offer_random(75, 5);

      // The receiver holds off for a long stretch while requests keep coming,
      // so the response register and the scan both fill and input stalls.
      hold_req = 1'b1;
      for (int i = 0; i < 40; i++) offer_random(35, 25);

      // Let every outstanding response drain before going on.
      wait_all_answered();

      // No idling on either side: requests are offered without gaps and responses always accepted.
      steady = 1'b1;
      for (int i = 0; i < 100; i++) offer_random(35, 25);
      steady = 1'b0;

      // Churn with random idling on both sides.
      for (int i = 0; i < 150; i++) offer_random(35, 25);

      // Drain phase: mostly removes, then a refill over a nearly empty pool.
      for (int i = 0; i < 90; i++) offer_random(15, 60);
      for (int i = 0; i < 30; i++) offer_random(60, 10);

      wait_all_answered();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("beam_slot_pool_table_unit: match");
      end else begin
         $display("beam_slot_pool_table_unit: mismatch");
      end
      $finish;
   end

endmodule
